>>> hw/rtl/flgf_pkg.sv
// shared constants, types and lookup functions for the fuel level gauge filter
// no dependencies; used by the core, the serial divider and the checker
package flgf_pkg;

    localparam int WINDOW_LEN = 20;
    localparam int ADC_BITS   = 12;

    localparam int BOUND_W    = 12;
    localparam int HALF_W     = 2 * BOUND_W;
    localparam int PCT_W      = 8;
    localparam int NUM_SEG    = 7;
    localparam int SEG_W      = 3;
    localparam int GEAR_W     = 3;
    localparam int SEG_MAX_W  = 7;
    localparam int BND_WORDS  = 4;
    localparam int BND_IDX_W  = 2;
    localparam int BND_D_W    = 24;
    localparam int THR_RESET  = 2854;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int POS_W      = $clog2(WINDOW_LEN);
    localparam int TOTAL_W    = $clog2(WINDOW_LEN * ((1 << ADC_BITS) - 1) + 1);
    localparam int AVG_SHIFT  = TOTAL_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W    = TOTAL_W + 2;
    localparam longint unsigned AVG_RECIP =
        ((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int CMP_W      = (ADC_BITS > BOUND_W) ? ADC_BITS : BOUND_W;

    localparam int DVD_W      = BOUND_W + SEG_MAX_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam logic [PCT_W-1:0] PCT_NO_SENDER = 8'hFF;
    localparam logic [PCT_W-1:0] PCT_FULL      = 8'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY     = 8'd0;
    localparam logic [SEG_W-1:0] SEG_LAST      = SEG_W'(NUM_SEG - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_BOUNDS_A  = 3'd1,
        CFG_BOUNDS_B  = 3'd2,
        CFG_BOUNDS_C  = 3'd3,
        CFG_BOUNDS_D  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // top percent of each calibration segment
    function automatic logic [SEG_MAX_W-1:0] seg_max(input logic [SEG_W-1:0] s);
        logic [SEG_MAX_W-1:0] r;
        unique case (s)
            3'd0:    r = 7'd13;
            3'd1:    r = 7'd27;
            3'd2:    r = 7'd41;
            3'd3:    r = 7'd55;
            3'd4:    r = 7'd69;
            3'd5:    r = 7'd83;
            3'd6:    r = 7'd100;
            default: r = 7'd100;
        endcase
        return r;
    endfunction

    // bottom percent of each calibration segment
    function automatic logic [SEG_MAX_W-1:0] seg_min(input logic [SEG_W-1:0] s);
        logic [SEG_MAX_W-1:0] r;
        unique case (s)
            3'd0:    r = 7'd0;
            3'd1:    r = 7'd14;
            3'd2:    r = 7'd28;
            3'd3:    r = 7'd42;
            3'd4:    r = 7'd56;
            3'd5:    r = 7'd70;
            3'd6:    r = 7'd84;
            default: r = 7'd84;
        endcase
        return r;
    endfunction

    // smallest percent shown for a gear
    function automatic logic [PCT_W-1:0] gear_floor(input logic [GEAR_W-1:0] g);
        logic [PCT_W-1:0] r;
        unique case (g)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd1;
            3'd2:    r = 8'd18;
            3'd3:    r = 8'd34;
            3'd4:    r = 8'd51;
            3'd5:    r = 8'd68;
            3'd6:    r = 8'd84;
            default: r = 8'd84;
        endcase
        return r;
    endfunction

    function automatic logic [GEAR_W-1:0] to_gear(input logic [PCT_W-1:0] p);
        logic [GEAR_W-1:0] g;
        priority if (p == 8'd0)  g = 3'd0;
        else if (p <= 8'd17)     g = 3'd1;
        else if (p <= 8'd33)     g = 3'd2;
        else if (p <= 8'd50)     g = 3'd3;
        else if (p <= 8'd67)     g = 3'd4;
        else if (p <= 8'd83)     g = 3'd5;
        else                     g = 3'd6;
        return g;
    endfunction

endpackage

>>> hw/rtl/flgf_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on flgf_pkg for operand widths and the status struct
module flgf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [flgf_pkg::DVD_W-1:0]    dividend,
    input  logic [flgf_pkg::BOUND_W-1:0]  divisor,
    output flgf_pkg::div_status_t         status,
    output logic [flgf_pkg::DVD_W-1:0]    quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [flgf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [flgf_pkg::DVD_W-1:0]       quo_reg, quo_next;
    logic [flgf_pkg::BOUND_W-1:0]     rem_reg, rem_next;
    logic [flgf_pkg::BOUND_W-1:0]     dvs_reg, dvs_next;

    logic [flgf_pkg::BOUND_W:0]       rem_sh;
    logic [flgf_pkg::BOUND_W:0]       rem_diff;
    logic                             ge;

    assign rem_sh   = {rem_reg, quo_reg[flgf_pkg::DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in its width
            rem_next = ge ? rem_diff[flgf_pkg::BOUND_W-1:0] : rem_sh[flgf_pkg::BOUND_W-1:0];
            quo_next = {quo_reg[flgf_pkg::DVD_W-2:0], ge};
            if (cnt_reg == flgf_pkg::DIV_CNT_W'(flgf_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

>>> hw/rtl/fuel_level_gauge_filter_core.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    adc_sample, startup_due, update_due, step_due
// out      out  out_valid / out_stall  percent, send_now, gear_pending
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item without an update passes the window step and the finish state; an update adds averaging,
// the threshold check, the segment scan (one segment a cycle), the multiply and the serial divider
// the first startup fills every window slot with its sample in place of averaging
// reset is asynchronous: window cleared, threshold 2854, all bounds zero
// the result waits in the output register; a new item is taken meanwhile, and the
// core holds in its final state while the previous result is still stalled
// depends on flgf_pkg and flgf_div
module fuel_level_gauge_filter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [flgf_pkg::ADC_BITS-1:0]     adc_sample,
    input  logic                              startup_due,
    input  logic                              update_due,
    input  logic                              step_due,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [flgf_pkg::PCT_W-1:0]        percent,
    output logic                              send_now,
    output logic                              gear_pending,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flgf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FILL   = 9'b000000010,
        ST_WIN    = 9'b000000100,
        ST_AVG    = 9'b000001000,
        ST_CHECK  = 9'b000010000,
        ST_SEARCH = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t                                state_reg, state_next;

    logic [flgf_pkg::ADC_BITS-1:0]         v_reg, v_next;
    logic                                  startup_reg, startup_next;
    logic                                  update_reg, update_next;
    logic                                  step_reg, step_next;
    logic                                  started_reg, started_next;

    logic [flgf_pkg::ADC_BITS-1:0]         win_reg [flgf_pkg::WINDOW_LEN];
    logic                                  win_we;
    logic [flgf_pkg::POS_W-1:0]            win_idx;
    logic [flgf_pkg::POS_W-1:0]            pos_reg, pos_next;
    logic [flgf_pkg::POS_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic [flgf_pkg::TOTAL_W-1:0]          total_reg, total_next;

    logic [flgf_pkg::ADC_BITS-1:0]         conv_v_reg, conv_v_next;
    logic [flgf_pkg::SEG_W-1:0]            seg_reg, seg_next;
    logic [flgf_pkg::PCT_W-1:0]            conv_pct_reg, conv_pct_next;

    logic [flgf_pkg::GEAR_W-1:0]           shown_gear_reg, shown_gear_next;
    logic                                  pending_reg, pending_next;

    logic                                  out_valid_reg, out_valid_next;
    logic [flgf_pkg::PCT_W-1:0]            out_pct_reg, out_pct_next;
    logic                                  out_send_reg, out_send_next;
    logic                                  out_pend_reg, out_pend_next;

    logic [flgf_pkg::BOUND_W-1:0]          thr_reg;
    logic [flgf_pkg::CFG_DATA_W-1:0]       bnd_reg [flgf_pkg::BND_WORDS];

    // segment bounds of the segment under test
    logic [flgf_pkg::CFG_DATA_W-1:0]       seg_word;
    logic [flgf_pkg::BOUND_W-1:0]          seg_up, seg_lo;
    logic [flgf_pkg::CMP_W-1:0]            cv, up_c, lo_c, thr_c, up0_c, diff_c;
    logic [flgf_pkg::BOUND_W-1:0]          span;
    logic                                  seg_hit;

    logic [flgf_pkg::TOTAL_W+flgf_pkg::RECIP_W-1:0] avg_prod;
    logic [flgf_pkg::DVD_W-1:0]            mul_prod;

    logic                                  div_start;
    flgf_pkg::div_status_t                 div_status;
    logic [flgf_pkg::DVD_W-1:0]            div_quo;
    logic [flgf_pkg::PCT_W-1:0]            div_rem_pct, div_min_pct;

    logic                                  in_take, out_free;
    logic [flgf_pkg::GEAR_W-1:0]           cur_gear;

    assign seg_word = bnd_reg[seg_reg[flgf_pkg::SEG_W-1:1]];
    assign seg_up   = seg_reg[0] ? seg_word[flgf_pkg::HALF_W +: flgf_pkg::BOUND_W]
                                 : seg_word[0 +: flgf_pkg::BOUND_W];
    assign seg_lo   = seg_reg[0] ? seg_word[flgf_pkg::HALF_W+flgf_pkg::BOUND_W +: flgf_pkg::BOUND_W]
                                 : seg_word[flgf_pkg::BOUND_W +: flgf_pkg::BOUND_W];

    assign cv      = flgf_pkg::CMP_W'(conv_v_reg);
    assign up_c    = flgf_pkg::CMP_W'(seg_up);
    assign lo_c    = flgf_pkg::CMP_W'(seg_lo);
    assign thr_c   = flgf_pkg::CMP_W'(thr_reg);
    assign up0_c   = flgf_pkg::CMP_W'(bnd_reg[0][flgf_pkg::BOUND_W-1:0]);
    assign seg_hit = (cv <= up_c) && (cv >= lo_c);
    assign diff_c  = cv - lo_c;
    assign span    = seg_up - seg_lo;

    assign avg_prod = flgf_pkg::TOTAL_W'(total_reg)
                    * flgf_pkg::RECIP_W'(flgf_pkg::AVG_RECIP);
    // sample inside the segment, so the offset fits in a bound field
    assign mul_prod = flgf_pkg::DVD_W'(diff_c[flgf_pkg::BOUND_W-1:0])
                    * flgf_pkg::DVD_W'(flgf_pkg::seg_max(seg_reg));

    assign div_min_pct = flgf_pkg::PCT_W'(flgf_pkg::seg_min(seg_reg));
    assign div_rem_pct = flgf_pkg::PCT_W'(flgf_pkg::seg_max(seg_reg))
                       - flgf_pkg::PCT_W'(div_quo[flgf_pkg::SEG_MAX_W-1:0]);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_gear  = flgf_pkg::to_gear(conv_pct_reg);
    assign div_start = (state_reg == ST_MUL) && (span != '0);

    flgf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (span),
        .status   (div_status),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        startup_next    = startup_reg;
        update_next     = update_reg;
        step_next       = step_reg;
        started_next    = started_reg;
        pos_next        = pos_reg;
        fill_cnt_next   = fill_cnt_reg;
        total_next      = total_reg;
        conv_v_next     = conv_v_reg;
        seg_next        = seg_reg;
        conv_pct_next   = conv_pct_reg;
        shown_gear_next = shown_gear_reg;
        pending_next    = pending_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_pct_next    = out_pct_reg;
        out_send_next   = out_send_reg;
        out_pend_next   = out_pend_reg;
        win_we          = 1'b0;
        win_idx         = pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    v_next        = adc_sample;
                    conv_v_next   = adc_sample;
                    startup_next  = !started_reg && startup_due;
                    update_next   = update_due && !(!started_reg && startup_due);
                    step_next     = step_due;
                    fill_cnt_next = '0;
                    if (!started_reg && startup_due)
                    begin
                        started_next = 1'b1;
                        state_next   = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_WIN;
                    end
                end
            end
            ST_FILL:
            begin
                win_we     = 1'b1;
                win_idx    = fill_cnt_reg;
                total_next = flgf_pkg::TOTAL_W'(v_reg * flgf_pkg::WINDOW_LEN);
                if (fill_cnt_reg == flgf_pkg::POS_W'(flgf_pkg::WINDOW_LEN - 1))
                    state_next = ST_WIN;
                else
                    fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            ST_WIN:
            begin
                win_we     = 1'b1;
                win_idx    = pos_reg;
                total_next = total_reg - flgf_pkg::TOTAL_W'(win_reg[pos_reg])
                           + flgf_pkg::TOTAL_W'(v_reg);
                if (pos_reg == flgf_pkg::POS_W'(flgf_pkg::WINDOW_LEN - 1))
                    pos_next = '0;
                else
                    pos_next = pos_reg + 1'b1;
                priority if (startup_reg) state_next = ST_CHECK;
                else if (update_reg)      state_next = ST_AVG;
                else                      state_next = ST_FINISH;
            end
            ST_AVG:
            begin
                // division by the window length as a reciprocal multiply
                conv_v_next = flgf_pkg::ADC_BITS'(avg_prod >> flgf_pkg::AVG_SHIFT);
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                seg_next = '0;
                if (cv >= thr_c)
                begin
                    conv_pct_next = flgf_pkg::PCT_NO_SENDER;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (seg_hit)
                begin
                    state_next = ST_MUL;
                end
                else if (seg_reg == flgf_pkg::SEG_LAST)
                begin
                    // no segment matches: empty when above segment zero
                    conv_pct_next = (cv > up0_c) ? flgf_pkg::PCT_EMPTY : flgf_pkg::PCT_FULL;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                if (span == '0)
                begin
                    conv_pct_next = flgf_pkg::PCT_W'(flgf_pkg::seg_max(seg_reg));
                    state_next    = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    conv_pct_next = (div_rem_pct < div_min_pct) ? div_min_pct : div_rem_pct;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = flgf_pkg::PCT_EMPTY;
                    out_send_next  = 1'b0;
                    priority if (startup_reg)
                    begin
                        shown_gear_next = cur_gear;
                        out_pct_next    = conv_pct_reg;
                        out_send_next   = 1'b1;
                    end
                    else if (update_reg)
                    begin
                        pending_next = (cur_gear != shown_gear_reg);
                        if (cur_gear == shown_gear_reg)
                        begin
                            out_pct_next  = conv_pct_reg;
                            out_send_next = 1'b1;
                        end
                        if (step_reg)
                        begin
                            out_send_next = 1'b1;
                            out_pct_next  = conv_pct_reg;
                            if (cur_gear != shown_gear_reg)
                            begin
                                // one gear step toward the measured gear
                                if (shown_gear_reg > cur_gear)
                                begin
                                    shown_gear_next = shown_gear_reg - 1'b1;
                                    out_pct_next    = flgf_pkg::gear_floor(shown_gear_reg - 1'b1);
                                end
                                else
                                begin
                                    shown_gear_next = shown_gear_reg + 1'b1;
                                    out_pct_next    = flgf_pkg::gear_floor(shown_gear_reg + 1'b1);
                                end
                            end
                        end
                    end
                    else
                    begin
                        out_send_next = 1'b0;
                    end
                    out_pend_next = (update_reg && !startup_reg)
                                  ? (cur_gear != shown_gear_reg) : pending_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            pos_reg        <= '0;
            fill_cnt_reg   <= '0;
            total_reg      <= '0;
            shown_gear_reg <= '0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            pos_reg        <= pos_next;
            fill_cnt_reg   <= fill_cnt_next;
            total_reg      <= total_next;
            shown_gear_reg <= shown_gear_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        startup_reg  <= startup_next;
        update_reg   <= update_next;
        step_reg     <= step_next;
        conv_v_reg   <= conv_v_next;
        seg_reg      <= seg_next;
        conv_pct_reg <= conv_pct_next;
        out_pct_reg  <= out_pct_next;
        out_send_reg <= out_send_next;
        out_pend_reg <= out_pend_next;
    end

    // sample window starts all zero so early updates average zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < flgf_pkg::WINDOW_LEN; i++)
                win_reg[i] <= '0;
        end
        else if (win_we)
        begin
            win_reg[win_idx] <= v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= flgf_pkg::BOUND_W'(flgf_pkg::THR_RESET);
            for (int i = 0; i < flgf_pkg::BND_WORDS; i++)
                bnd_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                flgf_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[flgf_pkg::BOUND_W-1:0];
                flgf_pkg::CFG_BOUNDS_A:  bnd_reg[0] <= cfg_data;
                flgf_pkg::CFG_BOUNDS_B:  bnd_reg[1] <= cfg_data;
                flgf_pkg::CFG_BOUNDS_C:  bnd_reg[2] <= cfg_data;
                flgf_pkg::CFG_BOUNDS_D:
                    bnd_reg[3] <= flgf_pkg::CFG_DATA_W'(cfg_data[flgf_pkg::BND_D_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign percent      = out_pct_reg;
    assign send_now     = out_send_reg;
    assign gear_pending = out_pend_reg;

endmodule

>>> hw/rtl/flgf_checker.sv
// port-level checks for the fuel level gauge filter core, bound to the core
// depends on flgf_pkg and fuel_level_gauge_filter_core
module flgf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [flgf_pkg::ADC_BITS-1:0]     adc_sample,
    input  logic                              startup_due,
    input  logic                              update_due,
    input  logic                              step_due,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [flgf_pkg::PCT_W-1:0]        percent,
    input  logic                              send_now,
    input  logic                              gear_pending,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [flgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flgf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(percent) && $stable(send_now)
            && $stable(gear_pending))
        else $error("stalled result changed");

    // core is busy right after taking a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("core ready right after a transaction");

    // nothing sent means percent reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_now |-> percent == flgf_pkg::PCT_EMPTY)
        else $error("percent nonzero without send");

    // a sent percent is a real level or the no-sender code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_now |-> percent <= flgf_pkg::PCT_FULL
            || percent == flgf_pkg::PCT_NO_SENDER)
        else $error("percent out of range");

endmodule

bind fuel_level_gauge_filter_core flgf_checker u_flgf_checker (.*);
